// ===== design/wavhp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared types and constants for the RIFF/WAVE PCM header parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

    // Widths of the stream payloads.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 176;

    // Tags as they read when four bytes are assembled little-endian.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // An fmt chunk at least this long carries an extra-size word.
    localparam logic [31:0] FMT_EXT_MIN = 32'd18;

    // Report status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF = 3'd1;
    localparam logic [2:0] ST_BAD_WAVE = 3'd2;
    localparam logic [2:0] ST_BAD_FMT  = 3'd3;
    localparam logic [2:0] ST_BAD_DATA = 3'd4;

    // Result kinds.
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    typedef enum logic [15:0] {
        PH_RIFF     = 16'h0001,
        PH_FSIZE    = 16'h0002,
        PH_WAVE     = 16'h0004,
        PH_FMT      = 16'h0008,
        PH_FMTSIZE  = 16'h0010,
        PH_FORMAT   = 16'h0020,
        PH_CHAN     = 16'h0040,
        PH_RATE     = 16'h0080,
        PH_BRATE    = 16'h0100,
        PH_BALIGN   = 16'h0200,
        PH_BPS      = 16'h0400,
        PH_CBSIZE   = 16'h0800,
        PH_SKIP     = 16'h1000,
        PH_DATATAG  = 16'h2000,
        PH_DATASIZE = 16'h4000,
        PH_DATA     = 16'h8000
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_size;
        logic [7:0]  data_byte;
        logic        last;
    } result_t;

endpackage

// ===== design/wav_header_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parser_core
// Parses a RIFF/WAVE PCM file streamed one byte per beat, emits one header
// report and then forwards the data chunk bytes.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle while s_axis_tready is high, with
// no gaps of its own: each byte only advances the header phase, assembles a
// little-endian field or counts down a skip or data length, all in the logic
// between the parser state registers and the output register. The output
// side has a register plus a skid stage, so a result produced while the
// master side stalls is held rather than lost; input tready drops only while
// both hold a result, and it opens again in the cycle after the master side
// takes the output beat. Set s_axis_tuser on the first byte of a file to
// restart parsing. After a bad tag the error report is sent with tlast set
// and further bytes are dropped until the next start; bytes after the last
// data byte are dropped the same way.
// ----------------------------------------------------------------------------
module wav_header_parser_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // byte_value
    input  logic         s_axis_tuser,   // frame_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, audio_format, channel_count, sample_rate, byte_rate, block_align,
    // bits_per_sample, data_size, data_byte, zero padding
    output logic [175:0] m_axis_tdata,
    output logic         m_axis_tuser,   // result_kind
    output logic         m_axis_tlast    // last
);

    wavhp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic        fmt_ext_reg, fmt_ext_next;
    logic [15:0] skip_reg, skip_next;
    logic [31:0] rem_reg, rem_next;
    logic [15:0] format_reg, format_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] balign_reg, balign_next;
    logic [15:0] bps_reg, bps_next;
    logic [31:0] dsize_reg, dsize_next;
    logic        err_reg, err_next;

    logic                 out_valid_reg;
    wavhp_pkg::result_t   out_data_reg;
    logic                 skid_valid_reg;
    wavhp_pkg::result_t   skid_data_reg;

    logic                 accept;
    logic                 res_valid;
    wavhp_pkg::result_t   res;

    // State as seen by this beat: a start flag clears it first.
    wavhp_pkg::phase_t cur_phase;
    logic [1:0]  cur_cnt;
    logic [31:0] cur_acc;
    logic        cur_fmt_ext;
    logic [15:0] cur_skip;
    logic [31:0] cur_rem;
    logic [15:0] cur_format, cur_chan, cur_balign, cur_bps;
    logic [31:0] cur_rate, cur_brate, cur_dsize;
    logic        cur_err;

    logic [31:0] acc_new;
    logic        need2;
    logic        field_done;
    logic [31:0] value;
    logic [15:0] skip_dec;
    logic [31:0] rem_dec;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (s_axis_tuser)
        begin
            cur_phase   = wavhp_pkg::PH_RIFF;
            cur_cnt     = 2'd0;
            cur_acc     = 32'd0;
            cur_fmt_ext = 1'b0;
            cur_skip    = 16'd0;
            cur_rem     = 32'd0;
            cur_format  = 16'd0;
            cur_chan    = 16'd0;
            cur_rate    = 32'd0;
            cur_brate   = 32'd0;
            cur_balign  = 16'd0;
            cur_bps     = 16'd0;
            cur_dsize   = 32'd0;
            cur_err     = 1'b0;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_cnt     = cnt_reg;
            cur_acc     = acc_reg;
            cur_fmt_ext = fmt_ext_reg;
            cur_skip    = skip_reg;
            cur_rem     = rem_reg;
            cur_format  = format_reg;
            cur_chan    = chan_reg;
            cur_rate    = rate_reg;
            cur_brate   = brate_reg;
            cur_balign  = balign_reg;
            cur_bps     = bps_reg;
            cur_dsize   = dsize_reg;
            cur_err     = err_reg;
        end
    end

    assign acc_new    = {s_axis_tdata, cur_acc[31:8]};
    assign need2      = (cur_phase inside {wavhp_pkg::PH_FORMAT, wavhp_pkg::PH_CHAN,
                                           wavhp_pkg::PH_BALIGN, wavhp_pkg::PH_BPS,
                                           wavhp_pkg::PH_CBSIZE});
    assign field_done = need2 ? (cur_cnt == 2'd1) : (cur_cnt == 2'd3);
    assign value      = need2 ? {16'd0, acc_new[31:16]} : acc_new;
    assign skip_dec   = (cur_skip != 16'd0) ? (cur_skip - 16'd1) : 16'd0;
    assign rem_dec    = cur_rem - 32'd1;

    always_comb
    begin
        phase_next   = cur_phase;
        cnt_next     = cur_cnt;
        acc_next     = cur_acc;
        fmt_ext_next = cur_fmt_ext;
        skip_next    = cur_skip;
        rem_next     = cur_rem;
        format_next  = cur_format;
        chan_next    = cur_chan;
        rate_next    = cur_rate;
        brate_next   = cur_brate;
        balign_next  = cur_balign;
        bps_next     = cur_bps;
        dsize_next   = cur_dsize;
        err_next     = cur_err;

        res_valid           = 1'b0;
        res                 = '0;
        res.kind            = wavhp_pkg::KIND_REPORT;
        res.audio_format    = cur_format;
        res.channel_count   = cur_chan;
        res.sample_rate     = cur_rate;
        res.byte_rate       = cur_brate;
        res.block_align     = cur_balign;
        res.bits_per_sample = cur_bps;
        res.data_size       = cur_dsize;
        res.last            = 1'b1;

        if (!cur_err)
        begin
            if (cur_phase == wavhp_pkg::PH_SKIP)
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_next = wavhp_pkg::PH_DATATAG;
                end
            end
            else if (cur_phase == wavhp_pkg::PH_DATA)
            begin
                if (cur_rem != 32'd0)
                begin
                    rem_next  = rem_dec;
                    res_valid = 1'b1;
                    res       = '0;
                    res.kind      = wavhp_pkg::KIND_DATA;
                    res.data_byte = s_axis_tdata;
                    res.last      = (rem_dec == 32'd0);
                end
            end
            else if (!field_done)
            begin
                cnt_next = cur_cnt + 2'd1;
                acc_next = acc_new;
            end
            else
            begin
                cnt_next = 2'd0;
                acc_next = 32'd0;
                case (cur_phase)
                    wavhp_pkg::PH_RIFF:
                    begin
                        if (value != wavhp_pkg::TAG_RIFF)
                        begin
                            err_next   = 1'b1;
                            res_valid  = 1'b1;
                            res.status = wavhp_pkg::ST_BAD_RIFF;
                        end
                        else
                        begin
                            phase_next = wavhp_pkg::PH_FSIZE;
                        end
                    end
                    wavhp_pkg::PH_FSIZE:
                    begin
                        phase_next = wavhp_pkg::PH_WAVE;
                    end
                    wavhp_pkg::PH_WAVE:
                    begin
                        if (value != wavhp_pkg::TAG_WAVE)
                        begin
                            err_next   = 1'b1;
                            res_valid  = 1'b1;
                            res.status = wavhp_pkg::ST_BAD_WAVE;
                        end
                        else
                        begin
                            phase_next = wavhp_pkg::PH_FMT;
                        end
                    end
                    wavhp_pkg::PH_FMT:
                    begin
                        if (value != wavhp_pkg::TAG_FMT)
                        begin
                            err_next   = 1'b1;
                            res_valid  = 1'b1;
                            res.status = wavhp_pkg::ST_BAD_FMT;
                        end
                        else
                        begin
                            phase_next = wavhp_pkg::PH_FMTSIZE;
                        end
                    end
                    wavhp_pkg::PH_FMTSIZE:
                    begin
                        fmt_ext_next = (value >= wavhp_pkg::FMT_EXT_MIN);
                        phase_next   = wavhp_pkg::PH_FORMAT;
                    end
                    wavhp_pkg::PH_FORMAT:
                    begin
                        format_next = value[15:0];
                        phase_next  = wavhp_pkg::PH_CHAN;
                    end
                    wavhp_pkg::PH_CHAN:
                    begin
                        chan_next  = value[15:0];
                        phase_next = wavhp_pkg::PH_RATE;
                    end
                    wavhp_pkg::PH_RATE:
                    begin
                        rate_next  = value;
                        phase_next = wavhp_pkg::PH_BRATE;
                    end
                    wavhp_pkg::PH_BRATE:
                    begin
                        brate_next = value;
                        phase_next = wavhp_pkg::PH_BALIGN;
                    end
                    wavhp_pkg::PH_BALIGN:
                    begin
                        balign_next = value[15:0];
                        phase_next  = wavhp_pkg::PH_BPS;
                    end
                    wavhp_pkg::PH_BPS:
                    begin
                        bps_next   = value[15:0];
                        phase_next = cur_fmt_ext ? wavhp_pkg::PH_CBSIZE
                                                 : wavhp_pkg::PH_DATATAG;
                    end
                    wavhp_pkg::PH_CBSIZE:
                    begin
                        skip_next  = value[15:0];
                        phase_next = (value[15:0] == 16'd0) ? wavhp_pkg::PH_DATATAG
                                                            : wavhp_pkg::PH_SKIP;
                    end
                    wavhp_pkg::PH_DATATAG:
                    begin
                        if (value != wavhp_pkg::TAG_DATA)
                        begin
                            err_next   = 1'b1;
                            res_valid  = 1'b1;
                            res.status = wavhp_pkg::ST_BAD_DATA;
                        end
                        else
                        begin
                            phase_next = wavhp_pkg::PH_DATASIZE;
                        end
                    end
                    wavhp_pkg::PH_DATASIZE:
                    begin
                        dsize_next    = value;
                        rem_next      = value;
                        phase_next    = wavhp_pkg::PH_DATA;
                        res_valid     = 1'b1;
                        res.status    = wavhp_pkg::ST_OK;
                        res.data_size = value;
                        res.last      = (value == 32'd0);
                    end
                    default:
                    begin
                        phase_next = cur_phase;
                    end
                endcase
            end
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= wavhp_pkg::PH_RIFF;
            cnt_reg     <= 2'd0;
            acc_reg     <= 32'd0;
            fmt_ext_reg <= 1'b0;
            skip_reg    <= 16'd0;
            rem_reg     <= 32'd0;
            format_reg  <= 16'd0;
            chan_reg    <= 16'd0;
            rate_reg    <= 32'd0;
            brate_reg   <= 32'd0;
            balign_reg  <= 16'd0;
            bps_reg     <= 16'd0;
            dsize_reg   <= 32'd0;
            err_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            fmt_ext_reg <= fmt_ext_next;
            skip_reg    <= skip_next;
            rem_reg     <= rem_next;
            format_reg  <= format_next;
            chan_reg    <= chan_next;
            rate_reg    <= rate_next;
            brate_reg   <= brate_next;
            balign_reg  <= balign_next;
            bps_reg     <= bps_next;
            dsize_reg   <= dsize_next;
            err_reg     <= err_next;
        end
    end

    // Output register with a skid stage: a result that arrives while the
    // output beat is stalled waits in the skid stage, which then closes tready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept && res_valid;
            end
        end
        else if (accept && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        else if (accept && res_valid)
        begin
            skid_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.kind;
    assign m_axis_tlast  = out_data_reg.last;
    assign m_axis_tdata  = {5'd0,
                            out_data_reg.data_byte,
                            out_data_reg.data_size,
                            out_data_reg.bits_per_sample,
                            out_data_reg.block_align,
                            out_data_reg.byte_rate,
                            out_data_reg.sample_rate,
                            out_data_reg.channel_count,
                            out_data_reg.audio_format,
                            out_data_reg.status};

endmodule

// ===== design/wavhp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_checker
// Port-level checks for the WAV header parser, bound to its top level.
// ----------------------------------------------------------------------------
module wavhp_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [175:0] m_axis_tdata,
    input logic         m_axis_tuser,
    input logic         m_axis_tlast
);

    // A stalled output beat stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload.
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // A data beat carries only its byte; all header fields read zero.
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[162:0] == 163'd0 && m_axis_tdata[175:171] == 5'd0)
        else $error("data beat carries header bits");

    // A header report has no data byte.
    a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[175:163] == 13'd0)
        else $error("header report carries a data byte");

    // An error report always ends the frame.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tlast)
        else $error("error report without tlast");

endmodule

bind wav_header_parser_core wavhp_checker u_wavhp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/wav_header_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parser_core_tb
// Self-checking bench for the RIFF/WAVE header parser. WAV files are built
// byte by byte, some whole, some cut short, some with a broken tag, and
// mixed with noise. They are streamed in under random source gaps and sink
// stalls. A behavioral parser kept in step with every accepted byte predicts
// each header report and forwarded data beat, and every beat leaving the
// block is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module wav_header_parser_core_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int N_DIRECTED   = 17;
    // The directed files take a little under 900 beats; this brings the
    // whole run to about 1800 input beats.
    localparam int RANDOM_ITEMS = 940;

    typedef enum int {NO_FAULT, FAULT_RIFF, FAULT_WAVE, FAULT_FMT, FAULT_DATA} tag_fault_t;
    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

    // One WAV file to stream in.
    typedef struct packed {
        bit          start;         // raise tuser on the first byte
        tag_fault_t  fault;         // which tag, if any, gets corrupted
        logic [31:0] fmt_len;
        logic [15:0] extra_len;     // extra-size word, sent when fmt_len >= 18
        logic [31:0] data_len;      // value written into the data size field
        int          data_sent;     // data bytes actually sent
        int          tail;          // junk bytes after the data
        int          cut;           // stop after this many bytes, 0 for none
        fill_t       fill;          // header field values
        bit          typed;         // header report given in the row itself
        logic [2:0]  typed_status;
    } wav_file_t;

    // Layout of m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [4:0]  pad;
        logic [7:0]  data_byte;
        logic [31:0] data_size;
        logic [15:0] bits_per_sample;
        logic [15:0] block_align;
        logic [31:0] byte_rate;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] audio_format;
        logic [2:0]  status;
    } report_bits_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'h00;
    logic         s_axis_tuser  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [175:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    // Behavioral parser state.
    wavhp_pkg::phase_t  parse_ph;
    logic [1:0]         fld_pos;
    logic [31:0]        acc;
    logic [31:0]        fmt_size;
    logic [15:0]        skip_left;
    logic [31:0]        data_left;
    wavhp_pkg::result_t hdr;
    logic               err_hold;

    wavhp_pkg::result_t parsed_beats [$];
    logic [7:0]         file_bytes [$];
    wavhp_pkg::result_t typed_report;
    bit          typed_armed   = 1'b0;
    int          sent_bytes    = 0;
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    wav_header_parser_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic flag_error(input string msg);
        error_count++;
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic clear_parser_state();
        parse_ph  = wavhp_pkg::PH_RIFF;
        fld_pos   = '0;
        acc       = '0;
        fmt_size  = '0;
        skip_left = '0;
        data_left = '0;
        hdr       = '0;
        err_hold  = 1'b0;
    endtask

    // Advances the parser by one byte; got is set when the byte yields a beat.
    task automatic parse_byte(input logic [7:0] b, input logic st,
                              output logic got, output wavhp_pkg::result_t r);
        logic [31:0] val;
        logic [2:0]  need;
        logic [2:0]  bad;
        logic        report;
        logic        lst;
        got    = 1'b0;
        r      = '0;
        bad    = wavhp_pkg::ST_OK;
        report = 1'b0;
        lst    = 1'b1;
        if (st)
            clear_parser_state();
        if (!err_hold)
        begin
            if (parse_ph == wavhp_pkg::PH_SKIP)
            begin
                if (skip_left != 0)
                    skip_left--;
                if (skip_left == 0)
                    parse_ph = wavhp_pkg::PH_DATATAG;
            end
            else if (parse_ph == wavhp_pkg::PH_DATA)
            begin
                if (data_left != 0)
                begin
                    data_left--;
                    r.kind      = wavhp_pkg::KIND_DATA;
                    r.data_byte = b;
                    r.last      = (data_left == 0);
                    got         = 1'b1;
                end
            end
            else
            begin
                acc = {b, acc[31:8]};
                case (parse_ph)
                    wavhp_pkg::PH_FORMAT, wavhp_pkg::PH_CHAN, wavhp_pkg::PH_BALIGN,
                    wavhp_pkg::PH_BPS, wavhp_pkg::PH_CBSIZE: need = 3'd2;
                    default: need = 3'd4;
                endcase
                if ({1'b0, fld_pos} + 3'd1 < need)
                    fld_pos++;
                else
                begin
                    // Two-byte fields end up in the upper half of the shifter.
                    val     = (need == 3'd2) ? {16'h0000, acc[31:16]} : acc;
                    fld_pos = '0;
                    acc     = '0;
                    case (parse_ph)
                        wavhp_pkg::PH_RIFF:
                            if (val != wavhp_pkg::TAG_RIFF)
                                bad = wavhp_pkg::ST_BAD_RIFF;
                            else
                                parse_ph = wavhp_pkg::PH_FSIZE;
                        wavhp_pkg::PH_FSIZE:   parse_ph = wavhp_pkg::PH_WAVE;
                        wavhp_pkg::PH_WAVE:
                            if (val != wavhp_pkg::TAG_WAVE)
                                bad = wavhp_pkg::ST_BAD_WAVE;
                            else
                                parse_ph = wavhp_pkg::PH_FMT;
                        wavhp_pkg::PH_FMT:
                            if (val != wavhp_pkg::TAG_FMT)
                                bad = wavhp_pkg::ST_BAD_FMT;
                            else
                                parse_ph = wavhp_pkg::PH_FMTSIZE;
                        wavhp_pkg::PH_FMTSIZE:
                        begin
                            fmt_size = val;
                            parse_ph = wavhp_pkg::PH_FORMAT;
                        end
                        wavhp_pkg::PH_FORMAT:
                        begin
                            hdr.audio_format = val[15:0];
                            parse_ph = wavhp_pkg::PH_CHAN;
                        end
                        wavhp_pkg::PH_CHAN:
                        begin
                            hdr.channel_count = val[15:0];
                            parse_ph = wavhp_pkg::PH_RATE;
                        end
                        wavhp_pkg::PH_RATE:
                        begin
                            hdr.sample_rate = val;
                            parse_ph = wavhp_pkg::PH_BRATE;
                        end
                        wavhp_pkg::PH_BRATE:
                        begin
                            hdr.byte_rate = val;
                            parse_ph = wavhp_pkg::PH_BALIGN;
                        end
                        wavhp_pkg::PH_BALIGN:
                        begin
                            hdr.block_align = val[15:0];
                            parse_ph = wavhp_pkg::PH_BPS;
                        end
                        wavhp_pkg::PH_BPS:
                        begin
                            hdr.bits_per_sample = val[15:0];
                            parse_ph = (fmt_size >= wavhp_pkg::FMT_EXT_MIN)
                                       ? wavhp_pkg::PH_CBSIZE : wavhp_pkg::PH_DATATAG;
                        end
                        wavhp_pkg::PH_CBSIZE:
                        begin
                            skip_left = val[15:0];
                            parse_ph  = (val[15:0] == 0) ? wavhp_pkg::PH_DATATAG
                                                         : wavhp_pkg::PH_SKIP;
                        end
                        wavhp_pkg::PH_DATATAG:
                            if (val != wavhp_pkg::TAG_DATA)
                                bad = wavhp_pkg::ST_BAD_DATA;
                            else
                                parse_ph = wavhp_pkg::PH_DATASIZE;
                        default:
                        begin
                            hdr.data_size = val;
                            data_left     = val;
                            parse_ph      = wavhp_pkg::PH_DATA;
                            report        = 1'b1;
                            lst           = (val == 0);
                        end
                    endcase
                    if (bad != wavhp_pkg::ST_OK)
                    begin
                        err_hold = 1'b1;
                        report   = 1'b1;
                    end
                    if (report)
                    begin
                        r           = hdr;
                        r.kind      = wavhp_pkg::KIND_REPORT;
                        r.status    = bad;
                        r.data_byte = 8'h00;
                        r.last      = lst;
                        got         = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic compare_beat(input wavhp_pkg::result_t got,
                                input wavhp_pkg::result_t want);
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("audio_format", 32'(got.audio_format), 32'(want.audio_format));
        check_field("channel_count", 32'(got.channel_count), 32'(want.channel_count));
        check_field("sample_rate", got.sample_rate, want.sample_rate);
        check_field("byte_rate", got.byte_rate, want.byte_rate);
        check_field("block_align", 32'(got.block_align), 32'(want.block_align));
        check_field("bits_per_sample", 32'(got.bits_per_sample),
                    32'(want.bits_per_sample));
        check_field("data_size", got.data_size, want.data_size);
        check_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
        check_field("last", 32'(got.last), 32'(want.last));
    endtask

    // Both handshakes are sampled here, input side first, at each rising edge.
    always @(posedge clk)
    begin : monitor_blk
        wavhp_pkg::result_t predicted;
        wavhp_pkg::result_t oldest;
        wavhp_pkg::result_t seen;
        report_bits_t       bits;
        logic               got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_byte(s_axis_tdata, s_axis_tuser, got, predicted);
                if (got)
                begin
                    if (typed_armed && predicted.kind == wavhp_pkg::KIND_REPORT)
                    begin
                        predicted   = typed_report;
                        typed_armed = 1'b0;
                    end
                    parsed_beats.push_back(predicted);
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                bits                 = m_axis_tdata;
                seen                 = '0;
                seen.kind            = m_axis_tuser;
                seen.status          = bits.status;
                seen.audio_format    = bits.audio_format;
                seen.channel_count   = bits.channel_count;
                seen.sample_rate     = bits.sample_rate;
                seen.byte_rate       = bits.byte_rate;
                seen.block_align     = bits.block_align;
                seen.bits_per_sample = bits.bits_per_sample;
                seen.data_size       = bits.data_size;
                seen.data_byte       = bits.data_byte;
                seen.last            = m_axis_tlast;
                check_field("tdata padding", 32'(bits.pad), 32'd0);
                if (parsed_beats.size() == 0)
                    flag_error("output beat with nothing expected");
                else
                begin
                    oldest = parsed_beats.pop_front();
                    compare_beat(seen, oldest);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic st);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_bytes++;
    endtask

    // Stops sending and waits until every predicted beat has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (parsed_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_le(input logic [31:0] v, input int n);
        int i;
        for (i = 0; i < n; i++)
            file_bytes.push_back(v[8 * i +: 8]);
    endtask

    task automatic send_file(input wav_file_t f);
        logic [15:0] fmt_code;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [15:0] balign;
        logic [15:0] bps;
        int          data_tag_at;
        int          pos;
        int          stop;
        int          i;
        case (f.fill)
            FILL_ZERO:
            begin
                fmt_code = '0; chans = '0; rate = '0; brate = '0; balign = '0; bps = '0;
            end
            FILL_ONES:
            begin
                fmt_code = '1; chans = '1; rate = '1; brate = '1; balign = '1; bps = '1;
            end
            default:
            begin
                fmt_code = 16'($urandom()); chans = 16'($urandom()); rate = $urandom();
                brate = $urandom(); balign = 16'($urandom()); bps = 16'($urandom());
            end
        endcase
        file_bytes.delete();
        push_le(wavhp_pkg::TAG_RIFF, 4);
        push_le($urandom(), 4);
        push_le(wavhp_pkg::TAG_WAVE, 4);
        push_le(wavhp_pkg::TAG_FMT, 4);
        push_le(f.fmt_len, 4);
        push_le({16'd0, fmt_code}, 2);
        push_le({16'd0, chans}, 2);
        push_le(rate, 4);
        push_le(brate, 4);
        push_le({16'd0, balign}, 2);
        push_le({16'd0, bps}, 2);
        if (f.fmt_len >= wavhp_pkg::FMT_EXT_MIN)
        begin
            push_le({16'd0, f.extra_len}, 2);
            for (i = 0; i < f.extra_len; i++)
                file_bytes.push_back(8'($urandom_range(255)));
        end
        data_tag_at = file_bytes.size();
        push_le(wavhp_pkg::TAG_DATA, 4);
        push_le(f.data_len, 4);
        for (i = 0; i < f.data_sent + f.tail; i++)
            file_bytes.push_back(8'($urandom_range(255)));

        case (f.fault)
            FAULT_RIFF: pos = 0;
            FAULT_WAVE: pos = 8;
            FAULT_FMT:  pos = 12;
            FAULT_DATA: pos = data_tag_at;
            default:    pos = -1;
        endcase
        if (pos >= 0)
        begin
            pos = pos + int'($urandom_range(3));
            file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(255, 1));
        end

        if (f.typed)
        begin
            typed_report        = '0;
            typed_report.kind   = wavhp_pkg::KIND_REPORT;
            typed_report.status = f.typed_status;
            typed_report.last   = 1'b1;
            typed_armed         = 1'b1;
        end

        stop = (f.cut > 0 && f.cut < file_bytes.size()) ? f.cut : file_bytes.size();
        for (i = 0; i < stop; i++)
            send_byte(file_bytes[i], (i == 0) ? f.start : 1'b0);
    endtask

    // Directed files. Only reports whose every field is plain from the row
    // itself are typed in; the rest go through the behavioral parser.
    function automatic wav_file_t directed_file(input int idx);
        case (idx)
            // First file after reset without tuser, all-zero header, empty data.
            0:  return '{1'b0, NO_FAULT,   32'd16, 16'd0, 32'd0, 0, 0, 0, FILL_ZERO,
                         1'b1, wavhp_pkg::ST_OK};
            // All-ones header; the junk after the data must be dropped.
            1:  return '{1'b1, NO_FAULT,   32'd16, 16'd0, 32'd3, 3, 3, 0, FILL_ONES,
                         1'b0, wavhp_pkg::ST_OK};
            2:  return '{1'b1, FAULT_RIFF, 32'd16, 16'd0, 32'd4, 4, 0, 0, FILL_RANDOM,
                         1'b1, wavhp_pkg::ST_BAD_RIFF};
            3:  return '{1'b1, FAULT_WAVE, 32'd16, 16'd0, 32'd4, 4, 0, 0, FILL_RANDOM,
                         1'b1, wavhp_pkg::ST_BAD_WAVE};
            4:  return '{1'b1, FAULT_FMT,  32'd16, 16'd0, 32'd4, 4, 0, 0, FILL_RANDOM,
                         1'b1, wavhp_pkg::ST_BAD_FMT};
            5:  return '{1'b1, FAULT_DATA, 32'd18, 16'd0, 32'd4, 4, 0, 0, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
            // fmt chunk just below the extension threshold.
            6:  return '{1'b1, NO_FAULT,   32'd17, 16'd7, 32'd2, 2, 0, 0, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
            // Extension present with a zero extra size.
            7:  return '{1'b1, NO_FAULT,   32'd18, 16'd0, 32'd1, 1, 0, 0, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
            8:  return '{1'b1, NO_FAULT,   32'd40, 16'd5, 32'd4, 4, 0, 0, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
            9:  return '{1'b1, NO_FAULT, 32'hFFFF_FFFF, 16'd1, 32'd2, 2, 0, 0, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
            // Largest extra size, abandoned partway through the skip.
            10: return '{1'b1, NO_FAULT,   32'd18, 16'hFFFF, 32'd2, 2, 0, 80, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
            // Largest data size: the parser stays in the data phase...
            11: return '{1'b1, NO_FAULT, 32'd16, 16'd0, 32'hFFFF_FFFF, 6, 0, 0, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
            // ...so a following file without tuser is forwarded as data.
            12: return '{1'b0, NO_FAULT,   32'd16, 16'd0, 32'd2, 2, 0, 0, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
            // Restart in the middle of the data.
            13: return '{1'b1, NO_FAULT,   32'd16, 16'd0, 32'd10, 10, 0, 49, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
            14: return '{1'b1, NO_FAULT,   32'd16, 16'd0, 32'd0, 0, 4, 0, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
            // No tuser after a finished file: everything is dropped.
            15: return '{1'b0, NO_FAULT,   32'd16, 16'd0, 32'd3, 3, 0, 0, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
            default:
                return '{1'b1, NO_FAULT,   32'd20, 16'd2, 32'd8, 8, 0, 0, FILL_RANDOM,
                         1'b0, wavhp_pkg::ST_OK};
        endcase
    endfunction

    function automatic wav_file_t random_file();
        wav_file_t f;
        f.start = ($urandom_range(9) != 0);
        f.fault = ($urandom_range(9) < 8) ? NO_FAULT : tag_fault_t'($urandom_range(4, 1));
        case ($urandom_range(4))
            0:       f.fmt_len = 32'd16;
            1:       f.fmt_len = 32'd17;
            2:       f.fmt_len = 32'd18;
            3:       f.fmt_len = $urandom_range(40, 19);
            default: f.fmt_len = $urandom();
        endcase
        f.extra_len = ($urandom_range(3) == 0) ? 16'($urandom_range(40))
                                               : 16'($urandom_range(3));
        if ($urandom_range(19) == 0)
        begin
            f.data_len  = $urandom();
            f.data_sent = int'($urandom_range(8));
        end
        else
        begin
            f.data_len  = $urandom_range(16);
            f.data_sent = int'(f.data_len);
        end
        f.tail         = ($urandom_range(4) == 0) ? int'($urandom_range(4, 1)) : 0;
        f.cut          = ($urandom_range(9) == 0) ? int'($urandom_range(60, 1)) : 0;
        f.fill         = ($urandom_range(9) == 0) ? fill_t'($urandom_range(1)) : FILL_RANDOM;
        f.typed        = 1'b0;
        f.typed_status = wavhp_pkg::ST_OK;
        return f;
    endfunction

    initial
    begin : stimulus_blk
        int phase_idx;
        int target;
        int n;
        int i;
        clear_parser_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 15;
        recv_stall_pct = 15;
        for (i = 0; i < N_DIRECTED; i++)
            send_file(directed_file(i));
        drain();

        // Idle mixes: none, source gaps, sink stalls, both.
        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            send_idle_pct  = (phase_idx == 1) ? 49 : (phase_idx == 3) ? 15 : 0;
            recv_stall_pct = (phase_idx == 2) ? 49 : (phase_idx == 3) ? 15 : 0;
            target = sent_bytes + RANDOM_ITEMS / 4;
            while (sent_bytes < target)
            begin
                if ($urandom_range(11) == 0)
                begin
                    n = int'($urandom_range(12, 1));
                    for (i = 0; i < n; i++)
                        send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
                end
                else
                    send_file(random_file());
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0 && parsed_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
